### sv/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the utf-8 to utf-16 stream transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_STRAY_CONT = 3'd1,
		ST_MISSING    = 3'd2,
		ST_BAD_CONT   = 3'd3,
		ST_BAD_LEAD   = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
		logic        run_last;
		logic        string_last;
	} result_t;

	// results produced by one decoded byte
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

### sv/utf8_to_utf16_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream
// Streaming utf-8 to utf-16 transcoder with per-byte error reporting.
// ----------------------------------------------------------------------------
// One utf-8 byte is taken per cycle while the queue has room (tlast marks
// the last byte of a string) and passes through an input register, then the
// decoder, into a four-entry result queue. A byte is taken every cycle as long
// as its results are single units and the output is ready; the output port
// moves one unit per ready cycle, so a byte yielding a surrogate pair costs
// two output transfers and the queue absorbs the difference. On an error one
// result with a nonzero status and tlast set is sent and the rest of the
// string is dropped; units already sent for that string should be discarded.
module utf8_to_utf16_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] run_last
	output logic        m_axis_tlast    // string_last
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eos_s1;
	logic               room;
	logic               adv;
	u8u16_pkg::push_t   push;
	u8u16_pkg::result_t out_res;

	assign adv           = valid_s1 & room;
	assign s_axis_tready = !valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready & s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	u8u16_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_byte (byte_s1),
		.eos     (eos_s1),
		.push    (push)
	);

	u8u16_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.code_unit;
	assign m_axis_tuser = {out_res.run_last, out_res.status};
	assign m_axis_tlast = out_res.string_last;

endmodule

### sv/u8u16_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte utf-8 decoder: character state registers plus the combinational
// step that turns one byte into zero, one or two utf-16 results.
// ----------------------------------------------------------------------------
module u8u16_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           in_byte,
	input  logic                 eos,
	output u8u16_pkg::push_t     push
);

	logic [1:0]  bytes_left_q;
	logic [20:0] partial_q;
	logic        bad_q;
	logic        dropping_q;

	logic [1:0]  bytes_left_d;
	logic [20:0] partial_d;
	logic        bad_d;
	logic        dropping_d;

	logic        cont_bad;
	logic [20:0] shifted;
	logic [1:0]  left_dec;
	logic [20:0] emit_cp;
	logic [20:0] emit_v;
	logic        do_emit;
	logic        do_fail;
	u8u16_pkg::status_t fail_st;

	assign cont_bad = bad_q | (in_byte[7:6] != 2'b10);
	assign shifted  = {partial_q[14:0], in_byte[5:0]};
	assign left_dec = bytes_left_q - 2'd1;
	assign emit_v   = emit_cp - 21'h010000;

	always_comb begin
		bytes_left_d = bytes_left_q;
		partial_d    = partial_q;
		bad_d        = bad_q;
		dropping_d   = dropping_q;
		do_emit      = 1'b0;
		do_fail      = 1'b0;
		fail_st      = u8u16_pkg::ST_OK;
		emit_cp      = 21'd0;

		if (dropping_q) begin
			if (eos) begin
				dropping_d   = 1'b0;
				bytes_left_d = 2'd0;
				partial_d    = 21'd0;
				bad_d        = 1'b0;
			end
		end else if (bytes_left_q != 2'd0) begin
			// any byte counts as a continuation while a character is pending
			bytes_left_d = left_dec;
			partial_d    = shifted;
			bad_d        = cont_bad;
			if (left_dec != 2'd0) begin
				if (eos) begin
					do_fail = 1'b1;
					fail_st = u8u16_pkg::ST_MISSING;
				end
			end else if (cont_bad) begin
				do_fail = 1'b1;
				fail_st = u8u16_pkg::ST_BAD_CONT;
			end else begin
				do_emit      = 1'b1;
				emit_cp      = shifted;
				bytes_left_d = 2'd0;
				partial_d    = 21'd0;
				bad_d        = 1'b0;
			end
		end else if (!in_byte[7]) begin
			do_emit = 1'b1;
			emit_cp = {13'd0, in_byte};
		end else if (in_byte[7:6] == 2'b10) begin
			do_fail = 1'b1;
			fail_st = u8u16_pkg::ST_STRAY_CONT;
		end else if (in_byte[7:3] == 5'b11111) begin
			do_fail = 1'b1;
			fail_st = u8u16_pkg::ST_BAD_LEAD;
		end else begin
			bad_d = 1'b0;
			if (in_byte[7:5] == 3'b110) begin
				partial_d    = {16'd0, in_byte[4:0]};
				bytes_left_d = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				partial_d    = {17'd0, in_byte[3:0]};
				bytes_left_d = 2'd2;
			end else begin
				partial_d    = {18'd0, in_byte[2:0]};
				bytes_left_d = 2'd3;
			end
			if (eos) begin
				do_fail = 1'b1;
				fail_st = u8u16_pkg::ST_MISSING;
			end
		end

		if (do_fail) begin
			bytes_left_d = 2'd0;
			partial_d    = 21'd0;
			bad_d        = 1'b0;
			dropping_d   = !eos;
		end
	end

	always_comb begin
		push.push0          = en & (do_emit | do_fail);
		push.push1          = 1'b0;
		push.r0.code_unit   = 16'd0;
		push.r0.status      = fail_st;
		push.r0.run_last    = 1'b1;
		push.r0.string_last = 1'b1;
		push.r1.code_unit   = {6'b110111, emit_v[9:0]};
		push.r1.status      = u8u16_pkg::ST_OK;
		push.r1.run_last    = 1'b1;
		push.r1.string_last = eos;
		if (do_emit) begin
			push.r0.status      = u8u16_pkg::ST_OK;
			push.r0.string_last = eos;
			if (emit_cp[20:16] != 5'd0) begin
				// surrogate pair, high unit first
				push.push1          = en;
				push.r0.code_unit   = {5'd0, emit_v[20:10]} | 16'hD800;
				push.r0.run_last    = 1'b0;
				push.r0.string_last = 1'b0;
			end else begin
				push.r0.code_unit = emit_cp[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			partial_q    <= 21'd0;
			bad_q        <= 1'b0;
			dropping_q   <= 1'b0;
		end else if (en) begin
			bytes_left_q <= bytes_left_d;
			partial_q    <= partial_d;
			bad_q        <= bad_d;
			dropping_q   <= dropping_d;
		end
	end

endmodule

### sv/u8u16_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_outq
// Small result queue: takes up to two results a cycle from the decoder and
// hands one result a cycle to the output stream while it is ready.
// ----------------------------------------------------------------------------
module u8u16_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8u16_pkg::push_t     push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u8u16_pkg::result_t   out_res
);

	u8u16_pkg::result_t mem_q [u8u16_pkg::QDEPTH];

	logic [u8u16_pkg::QPTR_W-1:0] wr_q;
	logic [u8u16_pkg::QPTR_W-1:0] rd_q;
	logic [u8u16_pkg::QCNT_W-1:0] count_q;
	logic [u8u16_pkg::QCNT_W-1:0] n_push;
	logic                         pop;

	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid & out_ready;
	// at least two free slots, so a surrogate pair always fits
	assign room      = count_q <= u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH - 2);
	assign n_push    = u8u16_pkg::QCNT_W'(push.push0) + u8u16_pkg::QCNT_W'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.push1) begin
			mem_q[wr_q + u8u16_pkg::QPTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[u8u16_pkg::QPTR_W-1:0];
			if (pop) begin
				rd_q <= rd_q + u8u16_pkg::QPTR_W'(1);
			end
			count_q <= count_q + n_push - u8u16_pkg::QCNT_W'(pop);
		end
	end

endmodule
